@@ rtl/core/ppack_pkg.sv @@
// Shared types and constants of the polar to rectangular spectrum packer.
package ppack_pkg;

  localparam int POS_W = 10;
  localparam int VAL_W = 24;
  localparam int PH_W  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_FROM_BIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TO_BIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OTHERS = 2'd2;

  localparam logic [POS_W-1:0] FROM_BIN_RST = 10'd0;
  localparam logic [POS_W-1:0] TO_BIN_RST   = 10'd513;

  // CORDIC datapath
  localparam int ITERS = 24;
  localparam int XW    = 34;          // x, y with guard bits and gain growth
  localparam int ZW    = 34;          // angle accumulator, 2^32 per turn
  localparam int KW    = 32;
  localparam int PW    = XW + KW;     // product width
  localparam int RSH   = 38;          // final scaling shift
  localparam logic signed [KW-1:0] K_GAIN = 32'sd652032874;

  localparam logic [31:0] ATAN [ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81
  };

  // queue between the classifier and the rotation pipeline
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic                    rotate;     // complex bin in range
    logic signed [VAL_W-1:0] magnitude;
    logic signed [PH_W-1:0]  phase;
    logic signed [VAL_W-1:0] re;         // result when not rotating
    logic signed [VAL_W-1:0] im;
  } entry_t;

endpackage

@@ rtl/core/ppack_if.sv @@
// Handshake channels of the spectrum packer: input items and results.
interface ppack_in_if import ppack_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] magnitude;
  logic signed [PH_W-1:0]  phase;
  logic signed [VAL_W-1:0] old_real;
  logic signed [VAL_W-1:0] old_imag;

  modport source (output valid, position, magnitude, phase, old_real, old_imag,
                  input ready);
  modport sink (input valid, position, magnitude, phase, old_real, old_imag,
                output ready);
endinterface

interface ppack_out_if import ppack_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        out_position;
  logic signed [VAL_W-1:0] real_part;
  logic signed [VAL_W-1:0] imag_part;

  modport source (output valid, out_position, real_part, imag_part, input ready);
  modport sink (input valid, out_position, real_part, imag_part, output ready);
endinterface

@@ rtl/core/ppack_front.sv @@
// Front part: configuration registers and classification of each input item.
module ppack_front import ppack_pkg::*; #(
  parameter int unsigned NBINS
) (
  input  logic                  clk,
  input  logic                  rst,
  ppack_in_if.sink              items,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  push_valid,
  input  logic                  push_ready,
  output entry_t                push_entry
);

  localparam int unsigned NYQ = NBINS + 1;

  logic [POS_W-1:0] from_bin;
  logic [POS_W-1:0] to_bin;
  logic             zero_others;
  logic             fvalid;
  entry_t           entry;
  entry_t           entry_next;
  logic [31:0]      pos_wide;
  logic             pos_ok;
  logic             in_range;
  logic             is_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      from_bin    <= FROM_BIN_RST;
      to_bin      <= TO_BIN_RST;
      zero_others <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FROM_BIN:    from_bin    <= cfg_data[POS_W-1:0];
        REG_TO_BIN:      to_bin      <= cfg_data[POS_W-1:0];
        REG_ZERO_OTHERS: zero_others <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign pos_wide = {{(32-POS_W){1'b0}}, items.position};
  assign pos_ok   = pos_wide <= 32'(NYQ);
  assign in_range = pos_ok && (items.position >= from_bin) && (items.position <= to_bin);
  assign is_end   = (items.position == '0) || (pos_wide == 32'(NYQ));

  always_comb begin
    entry_next.position  = items.position;
    entry_next.magnitude = items.magnitude;
    entry_next.phase     = items.phase;
    entry_next.rotate    = in_range && !is_end;
    if (in_range) begin
      // DC and Nyquist pass the value straight through
      entry_next.re = items.magnitude;
      entry_next.im = '0;
    end else if (zero_others) begin
      entry_next.re = '0;
      entry_next.im = '0;
    end else begin
      entry_next.re = items.old_real;
      entry_next.im = items.old_imag;
    end
  end

  assign items.ready = !fvalid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (items.ready) begin
      fvalid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      entry <= entry_next;
    end
  end

  assign push_valid = fvalid;
  assign push_entry = entry;

endmodule

@@ rtl/core/ppack_queue.sv @@
// Short queue of classified items between the front and the rotation pipeline.
module ppack_queue import ppack_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  entry_t           slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != QCW'(QDEPTH);
  assign head_valid = count != '0;
  assign head_entry = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ rtl/core/ppack_back.sv @@
// Back part: pipelined CORDIC rotation, gain scaling, saturation and output register.
module ppack_back import ppack_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  entry_t    head_entry,
  output logic      pop,
  ppack_out_if.source results
);

  localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (RSH - 1);
  localparam int QW = PW - RSH;

  logic                    adv;
  logic                    sv   [ITERS+1];
  logic                    srot [ITERS+1];
  logic [POS_W-1:0]        spos [ITERS+1];
  logic signed [XW-1:0]    sx   [ITERS+1];
  logic signed [XW-1:0]    sy   [ITERS+1];
  logic signed [ZW-1:0]    sz   [ITERS+1];

  logic                    mv;
  logic                    mrot;
  logic [POS_W-1:0]        mpos;
  logic signed [PW-1:0]    px;
  logic signed [PW-1:0]    py;
  logic signed [VAL_W-1:0] bre;
  logic signed [VAL_W-1:0] bim;

  logic                    ovalid;
  logic [POS_W-1:0]        opos;
  logic signed [VAL_W-1:0] ore;
  logic signed [VAL_W-1:0] oim;

  logic                    fold;
  logic signed [XW-1:0]    xs;
  logic signed [PW-1:0]    sum_x;
  logic signed [PW-1:0]    sum_y;

  function automatic logic signed [VAL_W-1:0] sat(input logic signed [QW-1:0] q);
    logic signed [QW-1:0] hi;
    logic signed [QW-1:0] lo;
    hi = QW'((1 << (VAL_W - 1)) - 1);
    lo = -QW'(1 << (VAL_W - 1));
    if (q > hi)      sat = hi[VAL_W-1:0];
    else if (q < lo) sat = lo[VAL_W-1:0];
    else             sat = q[VAL_W-1:0];
  endfunction

  // the whole pipeline moves together; hold everything while the result waits
  assign adv = !ovalid || results.ready;
  assign pop = adv && head_valid;

  // fold angles in the left half plane onto the right half
  assign fold = head_entry.phase[PH_W-1] ^ head_entry.phase[PH_W-2];
  assign xs   = {{(XW-VAL_W-8){head_entry.magnitude[VAL_W-1]}}, head_entry.magnitude, 8'h00};

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srot[0] <= head_entry.rotate;
      spos[0] <= head_entry.position;
      if (head_entry.rotate) begin
        sx[0] <= fold ? -xs : xs;
        sy[0] <= '0;
        sz[0] <= {{(ZW-32){head_entry.phase[PH_W-1] ^ fold}},
                  head_entry.phase[PH_W-1] ^ fold, head_entry.phase[PH_W-2:0], 16'h0000};
      end else begin
        sx[0] <= XW'(head_entry.re);
        sy[0] <= XW'(head_entry.im);
        sz[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < ITERS; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        srot[k+1] <= srot[k];
        spos[k+1] <= spos[k];
        if (!srot[k]) begin
          sx[k+1] <= sx[k];
          sy[k+1] <= sy[k];
          sz[k+1] <= sz[k];
        end else if (!sz[k][ZW-1]) begin
          sx[k+1] <= sx[k] - (sy[k] >>> k);
          sy[k+1] <= sy[k] + (sx[k] >>> k);
          sz[k+1] <= sz[k] - $signed({{(ZW-32){1'b0}}, ATAN[k]});
        end else begin
          sx[k+1] <= sx[k] + (sy[k] >>> k);
          sy[k+1] <= sy[k] - (sx[k] >>> k);
          sz[k+1] <= sz[k] + $signed({{(ZW-32){1'b0}}, ATAN[k]});
        end
      end
    end
  end

  // gain compensation
  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (adv) begin
      mv <= sv[ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mrot <= srot[ITERS];
      mpos <= spos[ITERS];
      px   <= PW'(sx[ITERS]) * PW'(K_GAIN);
      py   <= PW'(sy[ITERS]) * PW'(K_GAIN);
      bre  <= sx[ITERS][VAL_W-1:0];
      bim  <= sy[ITERS][VAL_W-1:0];
    end
  end

  // round half up, floor by the scaling shift, saturate
  assign sum_x = px + ROUND_HALF;
  assign sum_y = py + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (adv) begin
      ovalid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      opos <= mpos;
      ore  <= mrot ? sat(sum_x[PW-1:RSH]) : bre;
      oim  <= mrot ? sat(sum_y[PW-1:RSH]) : bim;
    end
  end

  assign results.valid        = ovalid;
  assign results.out_position = opos;
  assign results.real_part    = ore;
  assign results.imag_part    = oim;

endmodule

@@ rtl/core/polar_to_rect_spectrum_packer_unit.sv @@
// Top level of the polar to rectangular spectrum packer.
//
// Input items arrive on the items channel (valid/ready), one frame position
// each with magnitude, phase and the old contents at that position. Complex
// bins inside [from_bin, to_bin] are rotated by a 24-stage CORDIC and scaled
// by its inverse gain; DC and Nyquist inside the range pass the magnitude as real
// part. Other positions give zeros or the old contents, as zero_others says.
// One result per item leaves on the results channel, in order.
// Throughput is one item per cycle while the results side does not stall;
// every item, rotated or not, runs through the same pipeline: front register,
// queue, CORDIC stages, gain multiply and output register.
// A four-entry queue parts the classifier from the rotation pipeline. While
// the receiver stalls, the pipeline holds, the queue fills and then the
// items channel drops ready. Configuration writes take effect at the next
// edge; write them only while the block is empty. Reset clears all valid
// state and loads the register defaults: full range, old contents kept.
module polar_to_rect_spectrum_packer_unit import ppack_pkg::*; #(
  parameter int unsigned NBINS = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  ppack_in_if.sink              items,
  ppack_out_if.source           results,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;

  ppack_front #(
    .NBINS (NBINS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ppack_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  ppack_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .results    (results)
  );

endmodule
